// ----- design/brbd_pkg.sv -----
// Package for the banked ROM/RAM bus decoder: op codes, read source codes,
// memory command and response structs, address map constants.
// No dependencies.
package brbd_pkg;

    // Address map
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned ADDR_SPAN   = 65536;
    localparam int unsigned RAM_DEPTH_DEF = 65536;
    localparam int unsigned ROM_DEPTH   = 32768;
    localparam int unsigned ROM_AW      = $clog2(ROM_DEPTH);
    localparam int unsigned IO_REG_W    = 6;

    localparam logic [ADDR_W-1:0] IO_BASE  = 16'hFF00;
    localparam logic [ADDR_W-1:0] IO_LAST  = 16'hFF3F;
    localparam logic [ADDR_W-1:0] ROM_BASE = 16'h8000;
    localparam logic [DATA_W-1:0] UNMAPPED = 8'hFF;

    // Bus operation codes
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // Where the read byte of a result comes from
    typedef enum logic [2:0] {
        SRC_ZERO = 3'd0,
        SRC_FF   = 3'd1,
        SRC_IO   = 3'd2,
        SRC_RAM  = 3'd3,
        SRC_ROM  = 3'd4
    } t_src;

    // Memory command issued at the transfer edge
    typedef struct packed {
        logic              ram_en;
        logic              ram_we;
        logic              rom_en;
        logic              rom_we;
        logic [ROM_AW-1:0] rom_addr;
        logic [DATA_W-1:0] wdata;
    } t_mem_cmd;

    // Result information held while the memory read completes
    typedef struct packed {
        t_src                src;
        logic [DATA_W-1:0]   io_data;
        logic                io_select;
        logic                io_write;
        logic [IO_REG_W-1:0] io_register;
    } t_rsp_info;

endpackage

// ----- design/banked_rom_ram_bus_decoder_top.sv -----
// Banked ROM/RAM bus decoder. A result passes from its input transfer through stage 1
// (memory read) to the output register; stage 1 holds while the output stalls.
// Throughput: one access per cycle unless the output stalls, set by the single port of each store.
// Reset clears the control state and the RAM size select (16 KB model);
// RAM and ROM contents are undefined until written. Depends on brbd_pkg,
// brbd_decode and brbd_spram.
module banked_rom_ram_bus_decoder_top #(
    parameter int unsigned RAM_DEPTH = brbd_pkg::RAM_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_op,
    input  logic [brbd_pkg::ADDR_W-1:0]         i_addr,
    input  logic [brbd_pkg::DATA_W-1:0]         i_write_data,
    input  logic                                i_rom_mapped,
    input  logic [brbd_pkg::DATA_W-1:0]         i_io_read_data,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [brbd_pkg::DATA_W-1:0]         o_read_data,
    output logic                                o_io_select,
    output logic                                o_io_write,
    output logic [brbd_pkg::IO_REG_W-1:0]       o_io_register
);

    localparam int unsigned RAM_AW = $clog2(RAM_DEPTH);

    logic                           r_ram_is_64k;
    logic                           r_s1_vld;
    logic                           n_s1_vld;
    brbd_pkg::t_rsp_info            r_s1_info;
    logic                           r_o_vld;
    logic                           n_o_vld;
    logic [brbd_pkg::DATA_W-1:0]    r_read_data;
    logic [brbd_pkg::DATA_W-1:0]    n_read_data;
    logic                           r_io_select;
    logic                           r_io_write;
    logic [brbd_pkg::IO_REG_W-1:0]  r_io_register;

    brbd_pkg::t_mem_cmd             cmd;
    brbd_pkg::t_rsp_info            info;
    logic [RAM_AW-1:0]              ram_addr;
    logic [brbd_pkg::DATA_W-1:0]    ram_q;
    logic [brbd_pkg::DATA_W-1:0]    rom_q;
    logic                           out_free;
    logic                           s1_move;
    logic                           in_xfer;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_is_64k <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ram_is_64k <= i_cfg_data;
        end
    end

    // Handshake: stage 1 holds the item whose memory data is being read
    assign out_free   = !r_o_vld || !i_out_stall;
    assign s1_move    = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    brbd_decode #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_decode (
        .i_op           (i_op),
        .i_addr         (i_addr),
        .i_wdata        (i_write_data),
        .i_rom_mapped   (i_rom_mapped),
        .i_io_read_data (i_io_read_data),
        .i_ram_is_64k   (r_ram_is_64k),
        .o_cmd          (cmd),
        .o_ram_addr     (ram_addr),
        .o_info         (info)
    );

    // Stores, accessed only on an input transfer so read data holds in a stall
    brbd_spram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH (brbd_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (in_xfer && cmd.ram_en),
        .i_we    (cmd.ram_we),
        .i_addr  (ram_addr),
        .i_wdata (cmd.wdata),
        .o_rdata (ram_q)
    );

    brbd_spram #(
        .DEPTH (brbd_pkg::ROM_DEPTH),
        .WIDTH (brbd_pkg::DATA_W)
    ) u_rom (
        .i_clk   (i_clk),
        .i_en    (in_xfer && cmd.rom_en),
        .i_we    (cmd.rom_we),
        .i_addr  (cmd.rom_addr),
        .i_wdata (cmd.wdata),
        .o_rdata (rom_q)
    );

    // Next-state of the two valid flags
    assign n_s1_vld = in_xfer || (r_s1_vld && !s1_move);
    assign n_o_vld  = s1_move || (r_o_vld && i_out_stall);

    // Read byte select
    always_comb begin
        case (r_s1_info.src)
            brbd_pkg::SRC_IO:  n_read_data = r_s1_info.io_data;
            brbd_pkg::SRC_RAM: n_read_data = ram_q;
            brbd_pkg::SRC_ROM: n_read_data = rom_q;
            brbd_pkg::SRC_FF:  n_read_data = brbd_pkg::UNMAPPED;
            default:           n_read_data = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_o_vld  <= n_o_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_info <= info;
        end
        if (s1_move) begin
            r_read_data   <= n_read_data;
            r_io_select   <= r_s1_info.io_select;
            r_io_write    <= r_s1_info.io_write;
            r_io_register <= r_s1_info.io_register;
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_read_data   = r_read_data;
    assign o_io_select   = r_io_select;
    assign o_io_write    = r_io_write;
    assign o_io_register = r_io_register;

    // Checks
    a_xfer_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_s1_vld)
        else $error("transferred item missing from stage 1");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_move) |=> (r_s1_vld && $stable(r_s1_info)))
        else $error("stalled stage 1 item lost or changed");

    a_move_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> o_out_valid)
        else $error("result lost between stage 1 and output");

    a_io_write_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_io_write) |-> o_io_select)
        else $error("IO write flagged outside IO window");

    a_io_reg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_io_select) |-> (o_io_register == '0))
        else $error("IO register index nonzero outside IO window");

endmodule

// ----- design/brbd_spram.sv -----
// Single-port synchronous memory, one access per cycle, registered read data.
// Used for both the RAM and ROM stores. No package dependency.
module brbd_spram #(
    parameter int unsigned DEPTH = 32768,
    parameter int unsigned WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Write or read; read data is registered and held until the next read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_q <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_q;

endmodule

// ----- design/brbd_decode.sv -----
// Address decoder: turns one bus access into memory commands and the
// response information for the result. Depends on brbd_pkg.
module brbd_decode #(
    parameter int unsigned RAM_DEPTH = brbd_pkg::RAM_DEPTH_DEF
) (
    input  logic [1:0]                          i_op,
    input  logic [brbd_pkg::ADDR_W-1:0]         i_addr,
    input  logic [brbd_pkg::DATA_W-1:0]         i_wdata,
    input  logic                                i_rom_mapped,
    input  logic [brbd_pkg::DATA_W-1:0]         i_io_read_data,
    input  logic                                i_ram_is_64k,
    output brbd_pkg::t_mem_cmd                  o_cmd,
    output logic [$clog2(RAM_DEPTH)-1:0]        o_ram_addr,
    output brbd_pkg::t_rsp_info                 o_info
);

    localparam int unsigned RAM_AW     = $clog2(RAM_DEPTH);
    localparam int unsigned WRAP_STEPS = (brbd_pkg::ADDR_SPAN - 1) / RAM_DEPTH;

    logic in_io;
    logic in_upper;
    logic below_ram_size;

    assign in_io    = (i_addr >= brbd_pkg::IO_BASE) && (i_addr <= brbd_pkg::IO_LAST);
    assign in_upper = (i_addr >= brbd_pkg::ROM_BASE);
    // 16 KB model covers 0x0000-0x3FFF, 64 KB model the whole space
    assign below_ram_size = i_ram_is_64k || (i_addr[15:14] == 2'b00);

    // RAM index wraps modulo the store depth (WRAP_STEPS conditional subtracts)
    always_comb begin
        logic [brbd_pkg::ADDR_W-1:0] idx;
        idx = i_addr;
        for (int k = 0; k < WRAP_STEPS; k++) begin
            if ({1'b0, idx} >= 17'(RAM_DEPTH)) begin
                idx = idx - 16'(RAM_DEPTH);
            end
        end
        o_ram_addr = idx[RAM_AW-1:0];
    end

    // Access decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.rom_addr = i_addr[brbd_pkg::ROM_AW-1:0];
        o_cmd.wdata    = i_wdata;
        o_info             = '0;
        o_info.src         = brbd_pkg::SRC_ZERO;
        o_info.io_data     = i_io_read_data;
        case (brbd_pkg::t_op'(i_op))
            brbd_pkg::OP_READ: begin
                if (in_io) begin
                    o_info.src         = brbd_pkg::SRC_IO;
                    o_info.io_select   = 1'b1;
                    o_info.io_register = i_addr[brbd_pkg::IO_REG_W-1:0];
                end else if (in_upper && i_rom_mapped) begin
                    o_info.src   = brbd_pkg::SRC_ROM;
                    o_cmd.rom_en = 1'b1;
                end else if (below_ram_size || in_upper) begin
                    o_info.src   = brbd_pkg::SRC_RAM;
                    o_cmd.ram_en = 1'b1;
                end else begin
                    o_info.src = brbd_pkg::SRC_FF;
                end
            end
            brbd_pkg::OP_WRITE: begin
                if (in_io) begin
                    o_info.io_select   = 1'b1;
                    o_info.io_write    = 1'b1;
                    o_info.io_register = i_addr[brbd_pkg::IO_REG_W-1:0];
                end else if (below_ram_size) begin
                    o_cmd.ram_en = 1'b1;
                    o_cmd.ram_we = 1'b1;
                end
            end
            brbd_pkg::OP_LOAD: begin
                // upper address bit ignored: index is addr modulo ROM size
                o_cmd.rom_en = 1'b1;
                o_cmd.rom_we = 1'b1;
            end
            default: begin
                // no operation, all result fields zero
            end
        endcase
    end

endmodule

// ----- verif/brbd_access_checker.sv -----
// Checker for the banked ROM/RAM bus decoder. It follows the config, access and
// result channels, predicts every result and compares it field by field.
// Depends on brbd_pkg.
module brbd_access_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    input  logic                                    i_cfg_ready,
    input  logic                                    i_cfg_data,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_stall,
    input  logic [1:0]                              i_op,
    input  logic [brbd_pkg::ADDR_W-1:0]             i_addr,
    input  logic [brbd_pkg::DATA_W-1:0]             i_write_data,
    input  logic                                    i_rom_mapped,
    input  logic [brbd_pkg::DATA_W-1:0]             i_io_read_data,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_stall,
    input  logic [brbd_pkg::DATA_W-1:0]             i_read_data,
    input  logic                                    i_io_select,
    input  logic                                    i_io_write,
    input  logic [brbd_pkg::IO_REG_W-1:0]           i_io_register,
    output int                                      o_outstanding,
    output int                                      o_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    // One bus result as the block returns it
    typedef struct packed {
        logic [brbd_pkg::DATA_W-1:0]   read_data;
        logic                          io_select;
        logic                          io_write;
        logic [brbd_pkg::IO_REG_W-1:0] io_register;
    } t_bus_result;

    localparam logic [16:0] RAM_SIZE_16K = 17'd16384;
    localparam logic [16:0] RAM_SIZE_64K = 17'd65536;

    // Shadow copies of the stores and the RAM size select
    bit   [brbd_pkg::DATA_W-1:0] ram_img [0:brbd_pkg::ADDR_SPAN-1];
    bit   [brbd_pkg::DATA_W-1:0] rom_img [0:brbd_pkg::ROM_DEPTH-1];
    logic                        ram_64k_sel = 1'b0;
    t_bus_result                 result_q [$];
    int                          failures = 0;

    // Serve one access on the shadow map and return the result it produces
    function automatic t_bus_result serve_access(brbd_pkg::t_op acc_op,
                                                 logic [brbd_pkg::ADDR_W-1:0] acc_addr,
                                                 logic [brbd_pkg::DATA_W-1:0] wdata,
                                                 logic rom_on,
                                                 logic [brbd_pkg::DATA_W-1:0] io_data);
        t_bus_result res;
        logic [16:0] ram_limit;
        logic        in_window;
        res       = '0;
        ram_limit = ram_64k_sel ? RAM_SIZE_64K : RAM_SIZE_16K;
        in_window = (acc_addr >= brbd_pkg::IO_BASE) && (acc_addr <= brbd_pkg::IO_LAST);
        case (acc_op)
            brbd_pkg::OP_READ: begin
                res.read_data = brbd_pkg::UNMAPPED;
                if (in_window) begin
                    res.io_select   = 1'b1;
                    res.io_register = acc_addr[brbd_pkg::IO_REG_W-1:0];
                    res.read_data   = io_data;
                end else if (acc_addr >= brbd_pkg::ROM_BASE && rom_on) begin
                    // enabled ROM wins over RAM in the upper half
                    res.read_data = rom_img[acc_addr[brbd_pkg::ROM_AW-1:0]];
                end else if ({1'b0, acc_addr} < ram_limit
                             || acc_addr >= brbd_pkg::ROM_BASE) begin
                    res.read_data = ram_img[acc_addr];
                end
            end
            brbd_pkg::OP_WRITE: begin
                if (in_window) begin
                    res.io_select   = 1'b1;
                    res.io_write    = 1'b1;
                    res.io_register = acc_addr[brbd_pkg::IO_REG_W-1:0];
                end else if ({1'b0, acc_addr} < ram_limit) begin
                    ram_img[acc_addr] = wdata;
                end
            end
            brbd_pkg::OP_LOAD: begin
                // top address bit ignored, never an IO access
                rom_img[acc_addr[brbd_pkg::ROM_AW-1:0]] = wdata;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
            failures++;
        end
    endfunction

    // Follow every transfer in order: config, then access, then result
    always @(posedge i_clk) begin : watch
        t_bus_result exp_res;
        t_bus_result pred_res;
        if (!i_rst_n) begin
            ram_64k_sel = 1'b0;
            result_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                ram_64k_sel = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                pred_res = serve_access(brbd_pkg::t_op'(i_op), i_addr, i_write_data,
                                        i_rom_mapped, i_io_read_data);
                result_q = {result_q, pred_res};
            end
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result transfer with no access pending: read_data %0h",
                           i_read_data);
                    failures++;
                end else begin
                    exp_res = result_q.pop_front();
                    check_field("read_data", exp_res.read_data, i_read_data);
                    check_field("io_select", 8'(exp_res.io_select), 8'(i_io_select));
                    check_field("io_write", 8'(exp_res.io_write), 8'(i_io_write));
                    check_field("io_register", 8'(exp_res.io_register), 8'(i_io_register));
                end
            end
        end
        o_outstanding <= result_q.size();
        o_failures    <= failures;
    end

endmodule

// ----- verif/tb_banked_rom_ram_bus_decoder_top.sv -----
// Testbench top for the banked ROM/RAM bus decoder: clock, reset, access and
// config stimulus with random idling and result stalls, watchdog and verdict.
// Depends on brbd_pkg, banked_rom_ram_bus_decoder_top and brbd_access_checker.
module tb_banked_rom_ram_bus_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                          STALL_LIMIT     = 1000;
    localparam int                          RANDOM_PHASES   = 6;
    localparam int                          ITEMS_PER_PHASE = 265;
    localparam logic [brbd_pkg::ADDR_W-1:0] RAM_16K_TOP     = 16'h4000;

    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic                          cfg_data     = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic [1:0]                    op           = '0;
    logic [brbd_pkg::ADDR_W-1:0]   addr         = '0;
    logic [brbd_pkg::DATA_W-1:0]   write_data   = '0;
    logic                          rom_mapped   = 1'b0;
    logic [brbd_pkg::DATA_W-1:0]   io_read_data = '0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic [brbd_pkg::DATA_W-1:0]   read_data;
    logic                          io_select;
    logic                          io_write;
    logic [brbd_pkg::IO_REG_W-1:0] io_register;
    int                            outstanding;
    int                            failures;

    // Which store bytes hold known data, so no read lands on an unwritten one
    bit   ram_seen [0:brbd_pkg::ADDR_SPAN-1];
    bit   rom_seen [0:brbd_pkg::ROM_DEPTH-1];
    int   ram_list [$];
    int   rom_list [$];
    logic mode_64k  = 1'b0;
    bit   quiet     = 1'b0;
    int   gap_pct   = 20;
    int   n_read    = 0;
    int   n_write   = 0;
    int   n_load    = 0;
    int   n_nop     = 0;
    int   n_cfg     = 0;
    int   idle_cycles = 0;

    banked_rom_ram_bus_decoder_top u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_op           (op),
        .i_addr         (addr),
        .i_write_data   (write_data),
        .i_rom_mapped   (rom_mapped),
        .i_io_read_data (io_read_data),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_read_data    (read_data),
        .o_io_select    (io_select),
        .o_io_write     (io_write),
        .o_io_register  (io_register)
    );

    brbd_access_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_op           (op),
        .i_addr         (addr),
        .i_write_data   (write_data),
        .i_rom_mapped   (rom_mapped),
        .i_io_read_data (io_read_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_read_data    (read_data),
        .i_io_select    (io_select),
        .i_io_write     (io_write),
        .i_io_register  (io_register),
        .o_outstanding  (outstanding),
        .o_failures     (failures)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit io_window(logic [brbd_pkg::ADDR_W-1:0] a);
        return (a >= brbd_pkg::IO_BASE) && (a <= brbd_pkg::IO_LAST);
    endfunction

    // True when a read would return a store byte that was never written
    function automatic bit reads_unwritten(logic [brbd_pkg::ADDR_W-1:0] a, logic rom_on);
        if (io_window(a)) return 1'b0;
        if (a >= brbd_pkg::ROM_BASE && rom_on) return !rom_seen[a[brbd_pkg::ROM_AW-1:0]];
        if (a >= brbd_pkg::ROM_BASE || mode_64k || a < RAM_16K_TOP) return !ram_seen[a];
        return 1'b0;
    endfunction

    // Addresses cluster on the map boundaries so reads hit earlier writes
    function automatic logic [brbd_pkg::ADDR_W-1:0] pick_addr();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 16'h00FF));
            1:       return 16'($urandom_range(16'h3F00, 16'h40FF));
            2:       return 16'($urandom_range(16'h7F00, 16'h80FF));
            3:       return 16'($urandom_range(16'hFEC0, 16'hFF7F));
            4:       return 16'($urandom_range(16'hFFC0, 16'hFFFF));
            default: return 16'($urandom());
        endcase
    endfunction

    // Drain all results, then write the RAM size select
    task automatic write_ram_size(input logic sel_64k);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= sel_64k;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_64k = sel_64k;
        n_cfg++;
    endtask

    // One access transfer, with an optional idle burst ahead of it
    task automatic send_access(input brbd_pkg::t_op a_op,
                               input logic [brbd_pkg::ADDR_W-1:0] a_addr,
                               input logic [brbd_pkg::DATA_W-1:0] a_wdata,
                               input logic a_rom,
                               input logic [brbd_pkg::DATA_W-1:0] a_io);
        int gap;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op           <= a_op;
        addr         <= a_addr;
        write_data   <= a_wdata;
        rom_mapped   <= a_rom;
        io_read_data <= a_io;
        in_valid     <= 1'b1;
        do @(posedge clk); while (in_stall);
        // track what the stores now hold
        case (a_op)
            brbd_pkg::OP_READ:  n_read++;
            brbd_pkg::OP_WRITE: begin
                n_write++;
                if (!io_window(a_addr) && (mode_64k || a_addr < RAM_16K_TOP)
                        && !ram_seen[a_addr]) begin
                    ram_seen[a_addr] = 1'b1;
                    ram_list = {ram_list, int'(a_addr)};
                end
            end
            brbd_pkg::OP_LOAD: begin
                n_load++;
                if (!rom_seen[a_addr[brbd_pkg::ROM_AW-1:0]]) begin
                    rom_seen[a_addr[brbd_pkg::ROM_AW-1:0]] = 1'b1;
                    rom_list = {rom_list, int'(a_addr[brbd_pkg::ROM_AW-1:0])};
                end
            end
            default:  n_nop++;
        endcase
    endtask

    task automatic send_random_access();
        brbd_pkg::t_op               r_op;
        logic [brbd_pkg::ADDR_W-1:0] a;
        logic                        rom_on;
        int                          pick;
        pick   = $urandom_range(0, 99);
        a      = pick_addr();
        rom_on = 1'($urandom_range(0, 1));
        if (pick < 45)      r_op = brbd_pkg::OP_READ;
        else if (pick < 80) r_op = brbd_pkg::OP_WRITE;
        else if (pick < 96) r_op = brbd_pkg::OP_LOAD;
        else                r_op = brbd_pkg::OP_NOP;
        // steer reads onto bytes that hold known data
        if (r_op == brbd_pkg::OP_READ && reads_unwritten(a, rom_on)) begin
            if (rom_list.size() != 0 && $urandom_range(0, 1)) begin
                a      = brbd_pkg::ROM_BASE
                         | 16'(rom_list[$urandom_range(0, rom_list.size() - 1)]);
                rom_on = 1'b1;
            end else if (ram_list.size() != 0) begin
                a = 16'(ram_list[$urandom_range(0, ram_list.size() - 1)]);
                if (a >= brbd_pkg::ROM_BASE) rom_on = 1'b0;
            end
            if (reads_unwritten(a, rom_on)) a = brbd_pkg::IO_BASE + 16'($urandom_range(0, 63));
        end
        send_access(r_op, a, 8'($urandom()), rom_on, 8'($urandom()));
    endtask

    // Result side back-pressure in random bursts
    initial begin : result_backpressure
        int run;
        forever begin
            if (quiet) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                run = $urandom_range(1, 12);
                out_stall <= 1'b0;
                repeat (run) @(posedge clk);
                run = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: 16 KB model
        write_ram_size(1'b0);
        send_access(brbd_pkg::OP_WRITE, 16'h0000, 8'h00, 1'b0, 8'h00);
        send_access(brbd_pkg::OP_WRITE, 16'h3FFF, 8'hFF, 1'b1, 8'hFF);
        send_access(brbd_pkg::OP_READ,  16'h0000, 8'hFF, 1'b0, 8'h00);
        send_access(brbd_pkg::OP_READ,  16'h3FFF, 8'h00, 1'b1, 8'hFF);
        send_access(brbd_pkg::OP_WRITE, 16'h4000, 8'hAA, 1'b0, 8'h00);  // beyond RAM size
        send_access(brbd_pkg::OP_READ,  16'h4000, 8'h00, 1'b0, 8'h00);  // unmapped
        send_access(brbd_pkg::OP_READ,  16'h7FFF, 8'h00, 1'b1, 8'h00);  // unmapped, ROM ignored
        send_access(brbd_pkg::OP_READ,  16'hFF00, 8'h00, 1'b1, 8'hA5);
        send_access(brbd_pkg::OP_READ,  16'hFF3F, 8'h00, 1'b0, 8'h5A);
        send_access(brbd_pkg::OP_WRITE, 16'hFF00, 8'h12, 1'b0, 8'h00);
        send_access(brbd_pkg::OP_LOAD,  16'h8000, 8'h11, 1'b0, 8'h00);
        send_access(brbd_pkg::OP_LOAD,  16'hFFFF, 8'h22, 1'b0, 8'h00);
        send_access(brbd_pkg::OP_LOAD,  16'h7FFF, 8'h33, 1'b0, 8'h00);  // aliases onto top byte
        send_access(brbd_pkg::OP_READ,  16'hFFFF, 8'h00, 1'b1, 8'h00);
        send_access(brbd_pkg::OP_READ,  16'h8000, 8'h00, 1'b1, 8'h00);
        send_access(brbd_pkg::OP_LOAD,  16'hFF20, 8'h44, 1'b1, 8'hFF);  // load is never IO
        send_access(brbd_pkg::OP_NOP,   16'hFF10, 8'hFF, 1'b1, 8'hFF);

        // Directed: 64 KB model, ROM over RAM
        write_ram_size(1'b1);
        send_access(brbd_pkg::OP_WRITE, 16'hFF40, 8'h77, 1'b1, 8'h00);
        send_access(brbd_pkg::OP_WRITE, 16'h8000, 8'h5C, 1'b1, 8'h00);
        send_access(brbd_pkg::OP_WRITE, 16'h4000, 8'h66, 1'b0, 8'h00);
        send_access(brbd_pkg::OP_READ,  16'h8000, 8'h00, 1'b1, 8'h00);
        send_access(brbd_pkg::OP_READ,  16'h8000, 8'h00, 1'b0, 8'h00);
        send_access(brbd_pkg::OP_READ,  16'hFF40, 8'h00, 1'b0, 8'h00);
        send_access(brbd_pkg::OP_READ,  16'h4000, 8'h00, 1'b0, 8'h00);

        // Directed: back to 16 KB, ROM off reads upper RAM, middle unmapped
        write_ram_size(1'b0);
        send_access(brbd_pkg::OP_READ,  16'h8000, 8'h00, 1'b0, 8'h00);
        send_access(brbd_pkg::OP_READ,  16'h4000, 8'h00, 1'b0, 8'h00);

        // Random phases, alternating the RAM size; the last one runs without idling
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_ram_size(phase[0] ? 1'b0 : 1'b1);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            if (phase == RANDOM_PHASES - 1) quiet = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_random_access();
            end
        end

        // Drain and give the verdict
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
        $display("covered %0d reads, %0d writes, %0d ROM loads, %0d no-ops, %0d RAM size writes",
                 n_read, n_write, n_load, n_nop, n_cfg);
        $display("distinct RAM bytes written %0d, distinct ROM bytes loaded %0d",
                 ram_list.size(), rom_list.size());
        if (failures == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- banked_rom_ram_bus_decoder_top.f -----
design/brbd_pkg.sv
design/brbd_spram.sv
design/brbd_decode.sv
design/banked_rom_ram_bus_decoder_top.sv
verif/brbd_access_checker.sv
verif/tb_banked_rom_ram_bus_decoder_top.sv
